/* rtl/hvfc_pkg.sv */
// Shared types, constants and rounding and saturation helpers for the horizontal velocity force controller.
package hvfc_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned CmdFrac  = 15;
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegW     = 31;
  localparam int unsigned CfgIdxW  = 3;

  localparam int unsigned ForceLat = 8;
  localparam int unsigned RootW    = 32;
  localparam int unsigned LimQuoW  = 31;
  localparam int unsigned AccQuoW  = 32;
  localparam int unsigned MassLat  = ForceLat + RootW + LimQuoW;
  localparam int unsigned VldDepth = MassLat + 1 + AccQuoW;

  localparam logic [RegW-1:0] MassOne = RegW'(1) << FracBits;

  localparam logic [RegW-1:0] MaxSpeedRst     = 31'd39321600;
  localparam logic [RegW-1:0] VelocityGainRst = 31'd655360;
  localparam logic [RegW-1:0] DampingGainRst  = 31'd0;
  localparam logic [RegW-1:0] AirFactorRst    = 31'd19661;
  localparam logic [RegW-1:0] ForceLimitRst   = 31'h7FFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    RegMaxSpeed     = 3'd0,
    RegVelocityGain = 3'd1,
    RegDampingGain  = 3'd2,
    RegAirFactor    = 3'd3,
    RegForceLimit   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [RegW-1:0] max_speed;
    logic [RegW-1:0] velocity_gain;
    logic [RegW-1:0] damping_gain;
    logic [RegW-1:0] air_factor;
    logic [RegW-1:0] force_limit;
  } gains_t;

  function automatic logic [63:0] round_shift(input logic [63:0] p, input int unsigned s);
    round_shift = (p + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic signed [31:0] sat_sm(input logic neg, input logic [63:0] mag);
    logic signed [31:0] r;
    if (neg) begin
      r = (mag >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(mag[31:0]);
    end else begin
      r = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_s(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -65'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

/* rtl/hvfc_delay.sv */
// Enabled shift line that carries side data alongside the long arithmetic units.
module hvfc_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] din_i,
  output logic [WIDTH-1:0] dout_o
);

  logic [WIDTH-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= din_i;
      for (int k = 1; k < DEPTH; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  assign dout_o = line_q[DEPTH-1];

endmodule

/* rtl/hvfc_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module hvfc_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [2*hvfc_pkg::RootW-1:0] rad_i,
  output logic [hvfc_pkg::RootW-1:0]   root_o
);

  localparam int unsigned Steps = hvfc_pkg::RootW;
  localparam int unsigned RadW  = 2 * Steps;
  localparam int unsigned RemW  = Steps + 2;
  localparam int unsigned CatW  = RemW + 2;

  logic [RemW-1:0]  rem_q  [Steps];
  logic [Steps-1:0] root_q [Steps];
  logic [RadW-1:0]  rad_q  [Steps];

  logic [RemW-1:0]  src_rem  [Steps];
  logic [Steps-1:0] src_root [Steps];
  logic [RadW-1:0]  src_rad  [Steps];
  logic [CatW-1:0]  cat_w    [Steps];
  logic [CatW-1:0]  trial_w  [Steps];
  logic             ge_w     [Steps];

  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      if (k == 0) begin
        src_rem[k]  = '0;
        src_root[k] = '0;
        src_rad[k]  = rad_i;
      end else begin
        src_rem[k]  = rem_q[k-1];
        src_root[k] = root_q[k-1];
        src_rad[k]  = rad_q[k-1];
      end
      cat_w[k]   = {src_rem[k], src_rad[k][RadW-1:RadW-2]};
      trial_w[k] = {2'b00, src_root[k], 2'b01};
      ge_w[k]    = cat_w[k] >= trial_w[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Steps; k++) begin
        rem_q[k]  <= ge_w[k] ? RemW'(cat_w[k] - trial_w[k]) : RemW'(cat_w[k]);
        root_q[k] <= {src_root[k][Steps-2:0], ge_w[k]};
        rad_q[k]  <= src_rad[k] << 2;
      end
    end
  end

  assign root_o = root_q[Steps-1];

endmodule

/* rtl/hvfc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module hvfc_div #(
  parameter int unsigned DEN_W = 32,
  parameter int unsigned QUO_W = 31
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [DEN_W+QUO_W-1:0] num_i,
  input  logic [DEN_W-1:0]       den_i,
  output logic [QUO_W-1:0]       quo_o
);

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];

  logic [DEN_W-1:0] src_rem [QUO_W];
  logic [QUO_W-1:0] src_low [QUO_W];
  logic [QUO_W-1:0] src_quo [QUO_W];
  logic [DEN_W-1:0] src_den [QUO_W];
  logic [DEN_W:0]   trial_w [QUO_W];
  logic             ge_w    [QUO_W];

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        src_rem[k] = num_i[DEN_W+QUO_W-1:QUO_W];
        src_low[k] = num_i[QUO_W-1:0];
        src_quo[k] = '0;
        src_den[k] = den_i;
      end else begin
        src_rem[k] = rem_q[k-1];
        src_low[k] = low_q[k-1];
        src_quo[k] = quo_q[k-1];
        src_den[k] = den_q[k-1];
      end
      trial_w[k] = {src_rem[k], src_low[k][QUO_W-1]};
      ge_w[k]    = trial_w[k] >= {1'b0, src_den[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem_q[k] <= ge_w[k] ? DEN_W'(trial_w[k] - {1'b0, src_den[k]}) : DEN_W'(trial_w[k]);
        low_q[k] <= src_low[k] << 1;
        quo_q[k] <= {src_quo[k][QUO_W-2:0], ge_w[k]};
        den_q[k] <= src_den[k];
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

/* rtl/hvfc_force.sv */
// Eight-stage force datapath: desired velocity, gains, air scaling, squares and limit products.
module hvfc_force (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [31:0]    vel_x_i,
  input  logic signed [31:0]    vel_y_i,
  input  logic signed [15:0]    cmd_x_i,
  input  logic signed [15:0]    cmd_y_i,
  input  logic                  on_ground_i,
  input  hvfc_pkg::gains_t      gains_i,
  output logic signed [31:0]    force_o [2],
  output logic [62:0]           num_o [2],
  output logic [63:0]           len2_o,
  output logic                  exceed_o
);

  localparam int unsigned F = hvfc_pkg::FracBits;

  logic signed [31:0] vel [2];
  logic signed [15:0] cmd [2];
  logic [15:0]        cmd_mag [2];
  logic [31:0]        vel_mag [2];

  logic               cmd_neg_q [2];
  logic [46:0]        pc_q [2];
  logic               vel_neg_q [2];
  logic [62:0]        pq_q [2];
  logic signed [31:0] vel_s1_q [2];
  logic               grd_s1_q;

  logic signed [32:0] err_q [2];
  logic               qn_s2_q [2];
  logic [62:0]        qm_s2_q [2];
  logic               grd_s2_q;

  logic               err_neg_q [2];
  logic [63:0]        pp_q [2];
  logic               qn_s3_q [2];
  logic [62:0]        qm_s3_q [2];
  logic               grd_s3_q;

  logic signed [31:0] f_s4_q [2];
  logic               grd_s4_q;

  logic [62:0]        pa_q [2];
  logic signed [31:0] f_s5_q [2];
  logic               grd_s5_q;

  logic signed [31:0] f_s6_q [2];

  logic [31:0]        m_q [2];
  logic [63:0]        sq_q [2];
  logic signed [31:0] f_s7_q [2];
  logic [61:0]        lim2_q;

  logic signed [31:0] f_s8_q [2];
  logic [62:0]        num_q [2];
  logic [63:0]        len2_q;
  logic               exceed_q;

  logic signed [31:0] desired_w [2];
  logic [32:0]        err_mag_w [2];
  logic signed [64:0] ps_w [2];
  logic signed [64:0] qs_w [2];
  logic [31:0]        f5_mag_w [2];
  logic [31:0]        f7_mag_w [2];
  logic [63:0]        len2_w;

  assign vel[0] = vel_x_i;
  assign vel[1] = vel_y_i;
  assign cmd[0] = cmd_x_i;
  assign cmd[1] = cmd_y_i;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cmd_mag[i]   = cmd[i][15] ? 16'(-cmd[i]) : 16'(cmd[i]);
      vel_mag[i]   = vel[i][31] ? 32'(-vel[i]) : 32'(vel[i]);
      desired_w[i] = hvfc_pkg::sat_sm(cmd_neg_q[i],
                                      hvfc_pkg::round_shift(64'(pc_q[i]), hvfc_pkg::CmdFrac));
      err_mag_w[i] = err_q[i][32] ? 33'(-err_q[i]) : 33'(err_q[i]);
      ps_w[i]      = err_neg_q[i] ? -$signed(65'(hvfc_pkg::round_shift(pp_q[i], F)))
                                  :  $signed(65'(hvfc_pkg::round_shift(pp_q[i], F)));
      qs_w[i]      = qn_s3_q[i] ? -$signed(65'(qm_s3_q[i])) : $signed(65'(qm_s3_q[i]));
      f5_mag_w[i]  = f_s4_q[i][31] ? 32'(-f_s4_q[i]) : 32'(f_s4_q[i]);
      f7_mag_w[i]  = f_s6_q[i][31] ? 32'(-f_s6_q[i]) : 32'(f_s6_q[i]);
    end
    len2_w = sq_q[0] + sq_q[1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 2; i++) begin
        cmd_neg_q[i] <= cmd[i][15];
        pc_q[i]      <= 47'(cmd_mag[i]) * 47'(gains_i.max_speed);
        vel_neg_q[i] <= vel[i][31];
        pq_q[i]      <= 63'(vel_mag[i]) * 63'(gains_i.damping_gain);
        vel_s1_q[i]  <= vel[i];

        err_q[i]   <= 33'(desired_w[i]) - 33'(vel_s1_q[i]);
        qn_s2_q[i] <= vel_neg_q[i];
        qm_s2_q[i] <= 63'(hvfc_pkg::round_shift(64'(pq_q[i]), F));

        err_neg_q[i] <= err_q[i][32];
        pp_q[i]      <= 64'(err_mag_w[i]) * 64'(gains_i.velocity_gain);
        qn_s3_q[i]   <= qn_s2_q[i];
        qm_s3_q[i]   <= qm_s2_q[i];

        f_s4_q[i] <= hvfc_pkg::sat_s(ps_w[i] - qs_w[i]);

        pa_q[i]   <= 63'(f5_mag_w[i]) * 63'(gains_i.air_factor);
        f_s5_q[i] <= f_s4_q[i];

        f_s6_q[i] <= grd_s5_q ? f_s5_q[i]
                   : hvfc_pkg::sat_sm(f_s5_q[i][31],
                                      hvfc_pkg::round_shift(64'(pa_q[i]), F));

        m_q[i]    <= f7_mag_w[i];
        sq_q[i]   <= 64'(f7_mag_w[i]) * 64'(f7_mag_w[i]);
        f_s7_q[i] <= f_s6_q[i];

        f_s8_q[i] <= f_s7_q[i];
        num_q[i]  <= 63'(m_q[i]) * 63'(gains_i.force_limit);
      end
      grd_s1_q <= on_ground_i;
      grd_s2_q <= grd_s1_q;
      grd_s3_q <= grd_s2_q;
      grd_s4_q <= grd_s3_q;
      grd_s5_q <= grd_s4_q;
      lim2_q   <= 62'(gains_i.force_limit) * 62'(gains_i.force_limit);
      len2_q   <= len2_w;
      exceed_q <= len2_w > 64'(lim2_q);
    end
  end

  assign force_o  = f_s8_q;
  assign num_o    = num_q;
  assign len2_o   = len2_q;
  assign exceed_o = exceed_q;

endmodule

/* rtl/horizontal_velocity_force_ctrl_unit.sv */
// Throughput: one item per cycle; the whole pipeline holds while the output item is not taken.
// The pipeline runs the 8-stage force datapath, then the 32-stage square root, the 31-stage limit
// dividers and the 32-stage acceleration dividers, with registers between and after the dividers.
// Reset clears the valid bits and loads the default gains; data registers are not reset.
module horizontal_velocity_force_ctrl_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hvfc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hvfc_pkg::RegW-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [31:0]             vel_x_i,
  input  logic signed [31:0]             vel_y_i,
  input  logic signed [15:0]             cmd_x_i,
  input  logic signed [15:0]             cmd_y_i,
  input  logic                           on_ground_i,
  input  logic [hvfc_pkg::RegW-1:0]      body_mass_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             force_x_o,
  output logic signed [31:0]             force_y_o,
  output logic signed [31:0]             accel_x_o,
  output logic signed [31:0]             accel_y_o
);

  localparam int unsigned RegW = hvfc_pkg::RegW;
  localparam int unsigned VldD = hvfc_pkg::VldDepth;

  hvfc_pkg::gains_t gains_q;
  logic [VldD-1:0]  vld_q;
  logic             out_valid_q;
  logic             adv;

  logic signed [31:0] f_s8 [2];
  logic [62:0]        num_s8 [2];
  logic [63:0]        len2_s8;
  logic               exc_s8;
  logic [31:0]        len_w;

  logic [RegW-1:0]    mass_eff;
  logic [RegW-1:0]    mass_dl;

  logic               exc_d1;
  logic [62:0]        num_d1 [2];
  logic signed [31:0] f_d1 [2];
  logic               exc_d2;
  logic signed [31:0] f_d2 [2];
  logic [30:0]        lq [2];

  logic signed [31:0] fl_d [2];
  logic signed [31:0] fl_q [2];
  logic [RegW-1:0]    mass_q;
  logic [31:0]        fl_mag [2];
  logic [31:0]        aq [2];
  logic signed [31:0] fl_d3 [2];

  logic signed [31:0] force_q [2];
  logic signed [31:0] accel_q [2];

  logic [32:0]        fx_mag;
  logic [32:0]        fy_mag;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;
  assign mass_eff    = (body_mass_i < hvfc_pkg::MassOne) ? hvfc_pkg::MassOne : body_mass_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.max_speed     <= hvfc_pkg::MaxSpeedRst;
      gains_q.velocity_gain <= hvfc_pkg::VelocityGainRst;
      gains_q.damping_gain  <= hvfc_pkg::DampingGainRst;
      gains_q.air_factor    <= hvfc_pkg::AirFactorRst;
      gains_q.force_limit   <= hvfc_pkg::ForceLimitRst;
    end else if (cfg_valid_i) begin
      unique case (hvfc_pkg::cfg_reg_e'(cfg_index_i))
        hvfc_pkg::RegMaxSpeed:     gains_q.max_speed     <= cfg_data_i;
        hvfc_pkg::RegVelocityGain: gains_q.velocity_gain <= cfg_data_i;
        hvfc_pkg::RegDampingGain:  gains_q.damping_gain  <= cfg_data_i;
        hvfc_pkg::RegAirFactor:    gains_q.air_factor    <= cfg_data_i;
        hvfc_pkg::RegForceLimit:   gains_q.force_limit   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[VldD-2:0], in_valid_i};
      out_valid_q <= vld_q[VldD-1];
    end
  end

  hvfc_force u_force (
    .clk_i       (clk_i),
    .en_i        (adv),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .cmd_x_i     (cmd_x_i),
    .cmd_y_i     (cmd_y_i),
    .on_ground_i (on_ground_i),
    .gains_i     (gains_q),
    .force_o     (f_s8),
    .num_o       (num_s8),
    .len2_o      (len2_s8),
    .exceed_o    (exc_s8)
  );

  hvfc_delay #(.WIDTH(RegW), .DEPTH(hvfc_pkg::MassLat)) u_mass_dl (
    .clk_i  (clk_i),
    .en_i   (adv),
    .din_i  (mass_eff),
    .dout_o (mass_dl)
  );

  hvfc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (len2_s8),
    .root_o (len_w)
  );

  hvfc_delay #(.WIDTH(1 + 2*63 + 2*32), .DEPTH(hvfc_pkg::RootW)) u_root_dl (
    .clk_i  (clk_i),
    .en_i   (adv),
    .din_i  ({exc_s8, num_s8[0], num_s8[1], f_s8[0], f_s8[1]}),
    .dout_o ({exc_d1, num_d1[0], num_d1[1], f_d1[0], f_d1[1]})
  );

  hvfc_delay #(.WIDTH(1 + 2*32), .DEPTH(hvfc_pkg::LimQuoW)) u_lim_dl (
    .clk_i  (clk_i),
    .en_i   (adv),
    .din_i  ({exc_d1, f_d1[0], f_d1[1]}),
    .dout_o ({exc_d2, f_d2[0], f_d2[1]})
  );

  for (genvar i = 0; i < 2; i++) begin : g_lane
    hvfc_div #(.DEN_W(32), .QUO_W(hvfc_pkg::LimQuoW)) u_lim_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num_d1[i]),
      .den_i (len_w),
      .quo_o (lq[i])
    );

    assign fl_d[i]   = !exc_d2 ? f_d2[i]
                     : (f_d2[i][31] ? -$signed(32'(lq[i])) : $signed(32'(lq[i])));
    assign fl_mag[i] = fl_q[i][31] ? 32'(-fl_q[i]) : 32'(fl_q[i]);

    hvfc_div #(.DEN_W(RegW), .QUO_W(hvfc_pkg::AccQuoW)) u_acc_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (63'(fl_mag[i]) << hvfc_pkg::FracBits),
      .den_i (mass_q),
      .quo_o (aq[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fl_q   <= fl_d;
      mass_q <= mass_dl;
      for (int i = 0; i < 2; i++) begin
        force_q[i] <= fl_d3[i];
        accel_q[i] <= hvfc_pkg::sat_sm(fl_d3[i][31], 64'(aq[i]));
      end
    end
  end

  hvfc_delay #(.WIDTH(2*32), .DEPTH(hvfc_pkg::AccQuoW)) u_acc_dl (
    .clk_i  (clk_i),
    .en_i   (adv),
    .din_i  ({fl_q[0], fl_q[1]}),
    .dout_o ({fl_d3[0], fl_d3[1]})
  );

  assign out_valid_o = out_valid_q;
  assign force_x_o   = force_q[0];
  assign force_y_o   = force_q[1];
  assign accel_x_o   = accel_q[0];
  assign accel_y_o   = accel_q[1];

  assign fx_mag = force_x_o[31] ? (33'd0 - 33'(force_x_o)) : 33'(force_x_o);
  assign fy_mag = force_y_o[31] ? (33'd0 - 33'(force_y_o)) : 33'(force_y_o);

  a_force_x_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fx_mag <= 33'(gains_q.force_limit))
    else $error("Force X exceeds the force limit.");

  a_force_y_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fy_mag <= 33'(gains_q.force_limit))
    else $error("Force Y exceeds the force limit.");

  a_accel_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accel_x_o[31] && !force_x_o[31]) && !(accel_y_o[31] && !force_y_o[31]))
    else $error("Acceleration is negative while the force is not.");

endmodule
